### hw/rtl/smpp_pkg.sv
// Shared types, constants and the helper function of the permission-mode parser.
package smpp_pkg;

    localparam int WORD_W  = 9;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] WHO_U  = 9'b111000000;
    localparam logic [WORD_W-1:0] WHO_G  = 9'b000111000;
    localparam logic [WORD_W-1:0] WHO_O  = 9'b000000111;
    localparam logic [WORD_W-1:0] WHO_A  = 9'b111111111;
    localparam logic [WORD_W-1:0] PERM_R = 9'b100100100;
    localparam logic [WORD_W-1:0] PERM_W = 9'b010010010;
    localparam logic [WORD_W-1:0] PERM_X = 9'b001001001;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_SET    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_ASSIGN = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_WHO   = 3'd1,
        CLS_PERM  = 3'd2,
        CLS_OP    = 3'd3,
        CLS_COMMA = 3'd4
    } t_cls;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic                is_load;
        logic [WORD_W-1:0]   value;
        t_cls                cls;
        logic [WORD_W-1:0]   mask;
        t_op                 op;
        logic                is_digit;
        logic [DIGIT_W-1:0]  digit;
        logic                is_last;
    } t_token;

    function automatic logic [WORD_W-1:0] apply_op(
        input logic [WORD_W-1:0] word,
        input logic [WORD_W-1:0] who,
        input logic [WORD_W-1:0] bits,
        input t_op               op
    );
        logic [WORD_W-1:0] sel;
        logic [WORD_W-1:0] res;
        sel = who & bits;
        case (op)
            OP_SET:    res = word | sel;
            OP_CLEAR:  res = word & ~sel;
            OP_ASSIGN: res = (word & ~who) | sel;
            default:   res = word;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/smpp_if.sv
// Handshake interfaces for the request and result channels of the parser.
interface smpp_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [smpp_pkg::WORD_W-1:0]   value;
    logic [smpp_pkg::CHAR_W-1:0]   ch;
    logic                          is_last;

    modport source(output valid, action, value, ch, is_last, input ready);
    modport sink(input valid, action, value, ch, is_last, output ready);
endinterface

interface smpp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [smpp_pkg::WORD_W-1:0]   permissions;
    logic                          octal_form;

    modport source(output valid, permissions, octal_form, input ready);
    modport sink(input valid, permissions, octal_form, output ready);
endinterface

### hw/rtl/symbolic_permission_mode_parser_core.sv
// Top level of the symbolic and octal permission-mode parser.
//
// The block holds a nine-bit permission word. A request with action 0 loads
// the word from value and drops any string in progress; a request with
// action 1 carries one character of a mode string, and is_last marks the
// final one. Letters u, g, o, a build the class mask, r, w, x build the
// permission mask, and +, - and = select set, clear or assign; the pending
// operation is applied on a comma and at the end of the string. A string
// with no operator at all is read instead as the octal digits that lead it,
// keeping the low nine bits. Exactly one result (the final word, and a flag
// telling whether the octal form was used) comes out per string, after its
// last character; load requests and other characters give none. The block
// takes one request per clock cycle while the token queue is not full. The
// front end classifies each character and writes it into a four-entry token
// queue; the back end retires one token per cycle into the permission state,
// except that a token ending a string waits while the output register still
// holds an untaken result. A string's last character passes through the token
// queue and then the output register before its result is offered. The
// result sits in an output register. While it waits, the back end keeps
// retiring characters until the end of the next string reaches it; from then
// on the queue fills, and once its four entries are full the request side stalls.
module symbolic_permission_mode_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smpp_req_if.sink    i_req,
    smpp_rsp_if.source  o_rsp
);
    import smpp_pkg::*;

    logic   push;
    t_token push_tok;
    logic   queue_full;
    logic   tok_valid;
    t_token tok;
    logic   tok_pop;

    // Classify incoming characters; the queue's full flag sets request ready.
    smpp_front u_front (
        .i_req        (i_req),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_tok        (push_tok)
    );

    // Token queue that lets the request side run while a result waits.
    smpp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_tok (push_tok),
        .o_full     (queue_full),
        .o_valid    (tok_valid),
        .o_tok      (tok),
        .i_pop      (tok_pop)
    );

    // Permission state, mask building, operator application and result.
    smpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_pop   (tok_pop),
        .o_rsp       (o_rsp)
    );

endmodule

### hw/rtl/smpp_front.sv
// Front end: accepts requests and classifies each character into a token.
module smpp_front (
    smpp_req_if.sink                i_req,
    input  logic                    i_queue_full,
    output logic                    o_push,
    output smpp_pkg::t_token        o_tok
);
    import smpp_pkg::*;

    localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;

    assign i_req.ready = !i_queue_full;
    assign o_push      = i_req.valid && !i_queue_full;

    always_comb begin
        o_tok          = '0;
        o_tok.is_load  = !i_req.action;
        o_tok.value    = i_req.value;
        o_tok.is_last  = i_req.action && i_req.is_last;
        o_tok.cls      = CLS_OTHER;
        o_tok.mask     = '0;
        o_tok.op       = OP_NONE;
        o_tok.is_digit = (i_req.ch >= CH_ZERO) && (i_req.ch <= CH_SEVEN);
        o_tok.digit    = i_req.ch[DIGIT_W-1:0];
        case (i_req.ch)
            CH_U: begin
                o_tok.cls  = CLS_WHO;
                o_tok.mask = WHO_U;
            end
            CH_G: begin
                o_tok.cls  = CLS_WHO;
                o_tok.mask = WHO_G;
            end
            CH_O: begin
                o_tok.cls  = CLS_WHO;
                o_tok.mask = WHO_O;
            end
            CH_A: begin
                o_tok.cls  = CLS_WHO;
                o_tok.mask = WHO_A;
            end
            CH_R: begin
                o_tok.cls  = CLS_PERM;
                o_tok.mask = PERM_R;
            end
            CH_W: begin
                o_tok.cls  = CLS_PERM;
                o_tok.mask = PERM_W;
            end
            CH_X: begin
                o_tok.cls  = CLS_PERM;
                o_tok.mask = PERM_X;
            end
            CH_PLUS: begin
                o_tok.cls = CLS_OP;
                o_tok.op  = OP_SET;
            end
            CH_MINUS: begin
                o_tok.cls = CLS_OP;
                o_tok.op  = OP_CLEAR;
            end
            CH_EQ: begin
                o_tok.cls = CLS_OP;
                o_tok.op  = OP_ASSIGN;
            end
            CH_COMMA: begin
                o_tok.cls = CLS_COMMA;
            end
            default: begin
                o_tok.cls = CLS_OTHER;
            end
        endcase
    end

endmodule

### hw/rtl/smpp_queue.sv
// Small register queue of classified tokens between front end and back end.
module smpp_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  smpp_pkg::t_token        i_push_tok,
    output logic                    o_full,
    output logic                    o_valid,
    output smpp_pkg::t_token        o_tok,
    input  logic                    i_pop
);
    import smpp_pkg::*;

    t_token                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0]   r_wr;
    logic [QUEUE_IDX_W-1:0]   n_wr;
    logic [QUEUE_IDX_W-1:0]   r_rd;
    logic [QUEUE_IDX_W-1:0]   n_rd;
    logic [QUEUE_CNT_W-1:0]   r_cnt;
    logic [QUEUE_CNT_W-1:0]   n_cnt;
    logic                     push_ok;
    logic                     pop_ok;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr  = push_ok ? r_wr + 1'b1 : r_wr;
        n_rd  = pop_ok ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_push_tok;
        end
    end

endmodule

### hw/rtl/smpp_back.sv
// Back end: applies tokens to the permission state and registers the result.
module smpp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_tok_valid,
    input  smpp_pkg::t_token        i_tok,
    output logic                    o_tok_pop,
    smpp_rsp_if.source              o_rsp
);
    import smpp_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] r_who;
    logic [WORD_W-1:0] n_who;
    logic [WORD_W-1:0] r_bits;
    logic [WORD_W-1:0] n_bits;
    t_op               r_op;
    t_op               n_op;
    logic              r_op_seen;
    logic              n_op_seen;
    logic [WORD_W-1:0] r_oct;
    logic [WORD_W-1:0] n_oct;
    logic              r_oct_stop;
    logic              n_oct_stop;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [WORD_W-1:0] r_out_perm;
    logic [WORD_W-1:0] n_out_perm;
    logic              r_out_oct;
    logic              n_out_oct;
    logic              take;

    // A token that ends a string needs the result register free or being taken.
    assign take = i_tok_valid
        && (!i_tok.is_last || !r_out_valid || o_rsp.ready);
    assign o_tok_pop = take;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.permissions = r_out_perm;
    assign o_rsp.octal_form  = r_out_oct;

    always_comb begin
        n_word      = r_word;
        n_who       = r_who;
        n_bits      = r_bits;
        n_op        = r_op;
        n_op_seen   = r_op_seen;
        n_oct       = r_oct;
        n_oct_stop  = r_oct_stop;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_perm  = r_out_perm;
        n_out_oct   = r_out_oct;
        if (take) begin
            if (i_tok.is_load) begin
                n_word     = i_tok.value;
                n_who      = '0;
                n_bits     = '0;
                n_op       = OP_NONE;
                n_op_seen  = 1'b0;
                n_oct      = '0;
                n_oct_stop = 1'b0;
            end else begin
                if (!r_oct_stop) begin
                    if (i_tok.is_digit) begin
                        n_oct = {r_oct[WORD_W-DIGIT_W-1:0], i_tok.digit};
                    end else begin
                        n_oct_stop = 1'b1;
                    end
                end
                case (i_tok.cls)
                    CLS_WHO:  n_who  = r_who | i_tok.mask;
                    CLS_PERM: n_bits = r_bits | i_tok.mask;
                    CLS_OP: begin
                        n_op      = i_tok.op;
                        n_op_seen = 1'b1;
                    end
                    CLS_COMMA: begin
                        if (r_op != OP_NONE) begin
                            n_word = apply_op(r_word, r_who, r_bits, r_op);
                            n_who  = '0;
                            n_bits = '0;
                            n_op   = OP_NONE;
                        end
                    end
                    default: begin
                    end
                endcase
                if (i_tok.is_last) begin
                    n_word = apply_op(n_word, n_who, n_bits, n_op);
                    if (!n_op_seen) begin
                        n_word = n_oct;
                    end
                    n_out_valid = 1'b1;
                    n_out_perm  = n_word;
                    n_out_oct   = !n_op_seen;
                    n_who       = '0;
                    n_bits      = '0;
                    n_op        = OP_NONE;
                    n_op_seen   = 1'b0;
                    n_oct       = '0;
                    n_oct_stop  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_who       <= '0;
            r_bits      <= '0;
            r_op        <= OP_NONE;
            r_op_seen   <= 1'b0;
            r_oct       <= '0;
            r_oct_stop  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_word      <= n_word;
            r_who       <= n_who;
            r_bits      <= n_bits;
            r_op        <= n_op;
            r_op_seen   <= n_op_seen;
            r_oct       <= n_oct;
            r_oct_stop  <= n_oct_stop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_perm <= n_out_perm;
        r_out_oct  <= n_out_oct;
    end

endmodule

### hw/rtl/smpp_checker.sv
// Port-level assertions for the parser top level, and the bind that attaches them.
module smpp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [smpp_pkg::WORD_W-1:0]   i_rsp_permissions,
    input logic                          i_rsp_octal_form
);

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_permissions) && $stable(i_rsp_octal_form))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_rst_no_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result offered right after reset");

    // Reset empties the token queue, so requests are taken at once.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_req_ready)
        else $error("request side not ready after reset");

endmodule

bind symbolic_permission_mode_parser_core smpp_checker u_smpp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_permissions (o_rsp.permissions),
    .i_rsp_octal_form  (o_rsp.octal_form)
);

### tb/sv/tb.sv
// Self-checking testbench for the symbolic and octal permission-mode parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smpp_pkg::*;

    // Request actions.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_CHAR = 1'b1;

    // Characters that the parser gives a meaning to.
    localparam logic [CHAR_W-1:0] CH_U     = "u";
    localparam logic [CHAR_W-1:0] CH_G     = "g";
    localparam logic [CHAR_W-1:0] CH_O     = "o";
    localparam logic [CHAR_W-1:0] CH_A     = "a";
    localparam logic [CHAR_W-1:0] CH_R     = "r";
    localparam logic [CHAR_W-1:0] CH_W     = "w";
    localparam logic [CHAR_W-1:0] CH_X     = "x";
    localparam logic [CHAR_W-1:0] CH_PLUS  = "+";
    localparam logic [CHAR_W-1:0] CH_MINUS = "-";
    localparam logic [CHAR_W-1:0] CH_EQUAL = "=";
    localparam logic [CHAR_W-1:0] CH_COMMA = ",";
    localparam logic [CHAR_W-1:0] CH_ZERO  = "0";
    localparam logic [CHAR_W-1:0] CH_SEVEN = "7";
    localparam logic [CHAR_W-1:0] CH_SPACE = " ";
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TOP   = 8'hFF;

    localparam string WHO_LETTERS  = "ugoa";
    localparam string PERM_LETTERS = "rwx";
    localparam string OP_LETTERS   = "+-=";

    localparam int MAX_IDLE     = 13;
    localparam int LONG_HOLD    = 300;   // receiver hold-off that backs up the queue
    localparam int DRAIN_CYCLES = 4;     // settling margin after the last result
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASE_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 400000;

    typedef logic [CHAR_W-1:0] t_chars[$];

    typedef struct {
        logic [WORD_W-1:0] permissions;
        logic              octal_form;
    } t_mode_result;

    // Tracks the permission word the way the block should, and holds the
    // results that strings already accepted are still owed.
    class perm_tracker;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] who;
        logic [WORD_W-1:0] bits;
        logic [WORD_W-1:0] octal_acc;
        t_op               pend;
        bit                op_seen;
        bit                octal_stopped;
        t_mode_result      owed_results[$];
        int                mismatches;
        int                results_checked;
        int                octal_results;

        function new();
            word = '0;
            clear_string();
            mismatches = 0;
            results_checked = 0;
            octal_results = 0;
        endfunction

        function void clear_string();
            who = '0;
            bits = '0;
            pend = OP_NONE;
            op_seen = 0;
            octal_acc = '0;
            octal_stopped = 0;
        endfunction

        function void apply_pending();
            logic [WORD_W-1:0] sel;
            sel = who & bits;
            case (pend)
                OP_SET:    word = word | sel;
                OP_CLEAR:  word = word & ~sel;
                OP_ASSIGN: word = (word & ~who) | sel;
                default:   word = word;
            endcase
            who = '0;
            bits = '0;
            pend = OP_NONE;
        endfunction

        // Called once for every accepted request.
        function void note_request(logic act, logic [WORD_W-1:0] val,
                                   logic [CHAR_W-1:0] c, logic last);
            t_mode_result res;
            if (act == ACT_LOAD) begin
                word = val;
                clear_string();
                return;
            end
            if (!octal_stopped) begin
                if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    octal_acc = {octal_acc[WORD_W-4:0], 3'(c - CH_ZERO)};
                end else begin
                    octal_stopped = 1;
                end
            end
            case (c)
                CH_U:     who |= WHO_U;
                CH_G:     who |= WHO_G;
                CH_O:     who |= WHO_O;
                CH_A:     who |= WHO_A;
                CH_R:     bits |= PERM_R;
                CH_W:     bits |= PERM_W;
                CH_X:     bits |= PERM_X;
                CH_PLUS: begin
                    pend = OP_SET;
                    op_seen = 1;
                end
                CH_MINUS: begin
                    pend = OP_CLEAR;
                    op_seen = 1;
                end
                CH_EQUAL: begin
                    pend = OP_ASSIGN;
                    op_seen = 1;
                end
                CH_COMMA: begin
                    if (pend != OP_NONE) apply_pending();
                end
                default: ;
            endcase
            if (!last) return;
            if (pend != OP_NONE) apply_pending();
            if (!op_seen) word = octal_acc;
            res.permissions = word;
            res.octal_form = !op_seen;
            owed_results.push_back(res);
            clear_string();
        endfunction

        // Called once for every accepted result.
        function void check_result(logic [WORD_W-1:0] perm, logic octal);
            t_mode_result want;
            if (owed_results.size() == 0) begin
                $error("unexpected result: permissions %03o octal_form %0b", perm, octal);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            results_checked++;
            if (want.octal_form) octal_results++;
            if (perm !== want.permissions) begin
                $error("permissions: expected %03o, got %03o", want.permissions, perm);
                mismatches++;
            end
            if (octal !== want.octal_form) begin
                $error("octal_form: expected %0b, got %0b", want.octal_form, octal);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    smpp_req_if req();
    smpp_rsp_if rsp();

    symbolic_permission_mode_parser_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    perm_tracker tracker = new();

    // Idling switches, changed from phase to phase by the stimulus process.
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    // Set by the stimulus process to make the receiver stop for a long stretch.
    bit hold_req  = 1'b0;

    int requests_sent = 0;
    int loads_sent    = 0;
    int holds_done    = 0;
    int cycle_count   = 0;

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a correct run finishes far inside this many cycles.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL symbolic_permission_mode_parser_core");
            $finish;
        end
    end

    // Offers one request, after a random gap when idling is on, and returns
    // at the clock edge where it is accepted. Valid stays high afterwards so
    // that back-to-back requests need no second assignment in one step. All
    // handshake signals are sampled right at the edge, before any register
    // of the block has updated.
    task automatic send_request(input logic act, input logic [WORD_W-1:0] val,
                                input logic [CHAR_W-1:0] c, input logic last);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.action  <= act;
        req.value   <= val;
        req.ch      <= c;
        req.is_last <= last;
        do @(posedge clk); while (req.ready !== 1'b1);
        tracker.note_request(act, val, c, last);
        requests_sent++;
        if (act == ACT_LOAD) loads_sent++;
    endtask

    // A load ignores ch and is_last, so both are randomized to show that.
    task automatic send_load(input logic [WORD_W-1:0] val);
        send_request(ACT_LOAD, val, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Sends a whole mode string; unterminated strings leave is_last low.
    task automatic send_chars(input t_chars s, input bit terminate);
        foreach (s[i]) begin
            send_request(ACT_CHAR, WORD_W'($urandom_range(0, 511)), s[i],
                         terminate && (i == s.size() - 1));
        end
    endtask

    task automatic send_text(input string text);
        t_chars s;
        s = {};
        for (int i = 0; i < text.len(); i++) s.push_back(text[i]);
        send_chars(s, 1'b1);
    endtask

    // Stops offering requests until every owed result has arrived, then lets
    // the pipeline settle.
    task automatic drain_results();
        req.valid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One to three clauses of the form who-letters, operator(s), perm-letters,
    // with now and then a stray character, a missing who part or a trailing
    // comma.
    function automatic void build_symbolic(output t_chars s);
        int clauses;
        int n;
        s = {};
        clauses = $urandom_range(1, 3);
        for (int k = 0; k < clauses; k++) begin
            if (k > 0) s.push_back(CH_COMMA);
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
            repeat (n) s.push_back(WHO_LETTERS[$urandom_range(0, 3)]);
            n = ($urandom_range(0, 5) == 0) ? 2 : 1;
            repeat (n) s.push_back(OP_LETTERS[$urandom_range(0, 2)]);
            n = $urandom_range(0, 3);
            repeat (n) s.push_back(PERM_LETTERS[$urandom_range(0, 2)]);
            if ($urandom_range(0, 9) == 0) s.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0) s.push_back(CH_COMMA);
    endfunction

    // Octal digits, sometimes behind a blank or followed by other characters.
    function automatic void build_octal(output t_chars s);
        s = {};
        if ($urandom_range(0, 7) == 0) s.push_back(CH_SPACE);
        repeat ($urandom_range(1, 5)) s.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) == 0) begin
            s.push_back(CHAR_W'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2)) s.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 7)));
        end
    endfunction

    // Receiver: a random stall before each result, or the long hold-off when
    // the stimulus process asks for one. Ready then stays high until the next result.
    initial begin
        int gap;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                gap = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
                if (gap > 0) begin
                    rsp.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (rsp.valid !== 1'b1);
            tracker.check_result(rsp.permissions, rsp.octal_form);
        end
    end

    // Stimulus: reset, directed strings, a back-pressure burst, then random
    // phases with changing idle patterns.
    initial begin
        t_chars s;
        int next_phase;
        int pick;

        rst_n       <= 1'b0;
        req.valid   <= 1'b0;
        req.action  <= ACT_LOAD;
        req.value   <= '0;
        req.ch      <= '0;
        req.is_last <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A plain octal string straight after reset.
        send_text("777");
        // Assign with no permission letters wipes every class.
        send_load(9'h1FF);
        send_text("a=");
        // A comma applies the clause; an operator with no who letters is inert.
        send_text("o+x,=");
        // A lone NUL or 0xFF is a non-octal string with no operator: word 0.
        send_request(ACT_CHAR, 9'h1FF, CH_NUL, 1'b1);
        send_request(ACT_CHAR, 9'h000, CH_TOP, 1'b1);
        // A leading blank stops the octal digits before they start.
        send_text(" 7");
        // Several operators in a row: the last one is the one applied.
        send_load(9'h1FF);
        send_text("g+-r");
        // Digits past nine bits fall off the top.
        send_text("4567");
        // A load in the middle of a string throws the string away.
        send_request(ACT_CHAR, 9'h155, CH_U, 1'b0);
        send_request(ACT_CHAR, 9'h0AA, CH_PLUS, 1'b0);
        send_request(ACT_LOAD, 9'h000, CH_SEVEN, 1'b1);
        send_text("u+rwx");

        drain_results();

        // Back-pressure: the receiver stops for a long stretch while the
        // sender keeps offering one-digit strings with no gaps, so the token
        // queue and the output register fill and the input stalls.
        hold_req  = 1'b1;
        send_idle = 1'b0;
        repeat (30) begin
            send_request(ACT_CHAR, WORD_W'($urandom_range(0, 511)),
                         CH_ZERO + CHAR_W'($urandom_range(0, 7)), 1'b1);
        end
        drain_results();

        // Random part.
        next_phase = requests_sent;
        while (requests_sent < next_phase + RANDOM_ITEMS
               && requests_sent - next_phase < RANDOM_ITEMS + PHASE_ITEMS) begin
            if (requests_sent % PHASE_ITEMS < 8 && $urandom_range(0, 15) == 0) begin
                // Now and then the sender pauses until everything is back.
                drain_results();
            end
            if ($urandom_range(0, 39) == 0) begin
                send_idle = ($urandom_range(0, 2) != 0);
                recv_idle = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                send_load(WORD_W'($urandom_range(0, 511)));
                build_symbolic(s);
                send_chars(s, 1'b1);
            end else if (pick < 12) begin
                build_symbolic(s);
                send_chars(s, 1'b1);
            end else if (pick < 15) begin
                build_octal(s);
                send_chars(s, 1'b1);
            end else if (pick < 17) begin
                s = {};
                repeat ($urandom_range(1, 4)) s.push_back(CHAR_W'($urandom_range(0, 255)));
                send_chars(s, 1'b1);
            end else if (pick < 18) begin
                // A broken string: cut short by a load.
                build_symbolic(s);
                send_chars(s, 1'b0);
                send_load(WORD_W'($urandom_range(0, 511)));
            end else begin
                send_load(WORD_W'($urandom_range(0, 511)));
                build_octal(s);
                send_chars(s, 1'b1);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d loads) and checked %0d results, %0d in octal form.",
                 requests_sent, loads_sent, tracker.results_checked, tracker.octal_results);
        $display("Receiver held off %0d time(s) for %0d cycles; %0d mismatch(es) seen.",
                 holds_done, LONG_HOLD, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("PASS symbolic_permission_mode_parser_core");
        end else begin
            $display("FAIL symbolic_permission_mode_parser_core");
        end
        $finish;
    end

endmodule
